FILE: design/lrm_pkg.sv
// Shared types and constants for the Laue reflection multiplicity block.
// Holds the class and axis codes, the multiplicity values and the configuration struct.
// Used by lrm_calc and laue_reflection_multiplicity_top; depends on nothing else.
`default_nettype none

package lrm_pkg;

    // Laue class codes as held in the class register.
    localparam logic [3:0] LC_TRICLINIC   = 4'd0;   // -1
    localparam logic [3:0] LC_MONOCLINIC  = 4'd1;   // 2/m
    localparam logic [3:0] LC_ORTHO       = 4'd2;   // mmm
    localparam logic [3:0] LC_TETRA_LOW   = 4'd3;   // 4/m
    localparam logic [3:0] LC_TETRA_HIGH  = 4'd4;   // 4/mmm
    localparam logic [3:0] LC_CUBIC_LOW   = 4'd5;   // m-3
    localparam logic [3:0] LC_CUBIC_HIGH  = 4'd6;   // m-3m
    localparam logic [3:0] LC_HEX_LOW     = 4'd7;   // 6/m
    localparam logic [3:0] LC_HEX_HIGH    = 4'd8;   // 6/mmm
    localparam logic [3:0] LC_TRIG_R      = 4'd9;   // -3, rhombohedral axes
    localparam logic [3:0] LC_TRIG_H      = 4'd10;  // -3, hexagonal axes
    localparam logic [3:0] LC_TRIG_M_R    = 4'd11;  // -3m, rhombohedral axes
    localparam logic [3:0] LC_TRIG_M1_H   = 4'd12;  // -3.m, hexagonal axes
    localparam logic [3:0] LC_TRIG_M2_H   = 4'd13;  // -3m., hexagonal axes

    // Unique axis codes; the spare code behaves as c.
    localparam logic [1:0] AXIS_A = 2'd0;
    localparam logic [1:0] AXIS_B = 2'd1;
    localparam logic [1:0] AXIS_C = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [3:0] LAUE_CLASS_RESET  = LC_TRICLINIC;
    localparam logic [1:0] UNIQUE_AXIS_RESET = AXIS_C;

    // Register indexes on the configuration port.
    localparam logic REG_LAUE_CLASS  = 1'b0;
    localparam logic REG_UNIQUE_AXIS = 1'b1;

    // Multiplicity values.
    localparam logic [5:0] MULT_2  = 6'd2;
    localparam logic [5:0] MULT_4  = 6'd4;
    localparam logic [5:0] MULT_6  = 6'd6;
    localparam logic [5:0] MULT_8  = 6'd8;
    localparam logic [5:0] MULT_12 = 6'd12;
    localparam logic [5:0] MULT_16 = 6'd16;
    localparam logic [5:0] MULT_24 = 6'd24;
    localparam logic [5:0] MULT_48 = 6'd48;

    // Configuration handed from the register block to the calculator.
    typedef struct packed {
        logic [3:0] laue_class;
        logic [1:0] unique_axis;
    } cfg_t;

endpackage

`default_nettype wire

FILE: design/lrm_calc.sv
// Combinational multiplicity calculator for one Miller index triple.
// Forms the fourth hexagonal index, the zero tests and magnitudes, and picks the class result.
// Depends on lrm_pkg for class codes, multiplicity values and cfg_t.
`default_nettype none

module lrm_calc #(
    parameter int INDEX_WIDTH = 8
) (
    input  wire logic [INDEX_WIDTH-1:0] h,
    input  wire logic [INDEX_WIDTH-1:0] k,
    input  wire logic [INDEX_WIDTH-1:0] l,
    input  wire lrm_pkg::cfg_t          cfg,
    output logic [5:0]                  mult
);
    import lrm_pkg::*;

    localparam int W = INDEX_WIDTH;

    // Indices widened by two bits, enough for -h-k and h+k+l.
    logic signed [W+1:0] hx, kx, lx, ix, sum_hkl;
    assign hx      = {{2{h[W-1]}}, h};
    assign kx      = {{2{k[W-1]}}, k};
    assign lx      = {{2{l[W-1]}}, l};
    assign ix      = -hx - kx;
    assign sum_hkl = hx + kx + lx;

    // Magnitudes, one bit wider than the index so that the most negative value fits.
    logic [W:0] hs, ks, ls, mag_h, mag_k, mag_l;
    assign hs    = {h[W-1], h};
    assign ks    = {k[W-1], k};
    assign ls    = {l[W-1], l};
    assign mag_h = hs[W] ? (~hs + 1'b1) : hs;
    assign mag_k = ks[W] ? (~ks + 1'b1) : ks;
    assign mag_l = ls[W] ? (~ls + 1'b1) : ls;

    // Zero tests and their count.
    logic       zh, zk, zl, zi;
    logic [1:0] zeros;
    assign zh    = (h == '0);
    assign zk    = (k == '0);
    assign zl    = (l == '0);
    assign zi    = (ix == '0);
    assign zeros = {1'b0, zh} + {1'b0, zk} + {1'b0, zl};

    // Signed equalities, including those against the fourth index.
    logic eq_hk, eq_kl, eq_hl, eq_ki, eq_hi;
    assign eq_hk = (h == k);
    assign eq_kl = (k == l);
    assign eq_hl = (h == l);
    assign eq_ki = (kx == ix);
    assign eq_hi = (hx == ix);

    // Magnitude equalities.
    logic meq_hk, meq_kl, meq_hl;
    assign meq_hk = (mag_h == mag_k);
    assign meq_kl = (mag_k == mag_l);
    assign meq_hl = (mag_h == mag_l);

    // Unique axis first, the other two following in cyclic order.
    logic       zu, zp, zq;
    logic [W:0] mag_p, mag_q;
    always_comb
    begin
        unique case (cfg.unique_axis)
            AXIS_A:
            begin
                zu = zh; zp = zk; zq = zl;
                mag_p = mag_k; mag_q = mag_l;
            end
            AXIS_B:
            begin
                zu = zk; zp = zl; zq = zh;
                mag_p = mag_l; mag_q = mag_h;
            end
            default:
            begin
                zu = zl; zp = zh; zq = zk;
                mag_p = mag_h; mag_q = mag_k;
            end
        endcase
    end

    logic meq_pq;
    assign meq_pq = (mag_p == mag_q);

    // Result per Laue class; spare codes behave as triclinic.
    always_comb
    begin
        mult = MULT_2;
        unique case (cfg.laue_class)
            LC_MONOCLINIC:
            begin
                priority if (zu)            mult = MULT_2;
                else if (zp && zq)          mult = MULT_2;
                else                        mult = MULT_4;
            end
            LC_ORTHO:
            begin
                priority if (zeros == 2'd0) mult = MULT_8;
                else if (zeros == 2'd1)     mult = MULT_4;
                else                        mult = MULT_2;
            end
            LC_TETRA_LOW:
            begin
                priority if (zu)            mult = MULT_4;
                else if (zp && zq)          mult = MULT_2;
                else                        mult = MULT_8;
            end
            LC_TETRA_HIGH:
            begin
                priority if (zu)
                    mult = (zp || meq_pq || zq) ? MULT_4 : MULT_8;
                else if (zp)
                    mult = zq ? MULT_2 : MULT_8;
                else if (zq || meq_pq)
                    mult = MULT_8;
                else
                    mult = MULT_16;
            end
            LC_CUBIC_LOW:
            begin
                priority if (meq_hk && meq_kl) mult = MULT_8;
                else if (zeros == 2'd0)        mult = MULT_24;
                else if (zeros == 2'd1)        mult = MULT_12;
                else                           mult = MULT_6;
            end
            LC_CUBIC_HIGH:
            begin
                priority if (zeros == 2'd2)
                    mult = MULT_6;
                else if (zeros == 2'd1)
                    mult = (meq_hk || meq_kl || meq_hl) ? MULT_12 : MULT_24;
                else if (meq_hk)
                    mult = meq_kl ? MULT_8 : MULT_24;
                else if (meq_hl || meq_kl)
                    mult = MULT_24;
                else
                    mult = MULT_48;
            end
            LC_HEX_LOW:
            begin
                priority if (zl)            mult = MULT_6;
                else if (zh && zk)          mult = MULT_2;
                else                        mult = MULT_12;
            end
            LC_HEX_HIGH:
            begin
                priority if (zl)
                    mult = (zh || zk || zi || eq_hk || eq_ki || eq_hi) ? MULT_6 : MULT_12;
                else if (zh)
                    mult = zk ? MULT_2 : MULT_12;
                else if (zk || zi || eq_hk || eq_ki || eq_hi)
                    mult = MULT_12;
                else
                    mult = MULT_24;
            end
            LC_TRIG_R:
                mult = (eq_hk && eq_kl) ? MULT_2 : MULT_6;
            LC_TRIG_H:
                mult = (zh && zk) ? MULT_2 : MULT_6;
            LC_TRIG_M_R:
            begin
                priority if (eq_hk)
                    mult = eq_kl ? MULT_2 : MULT_6;
                else if (eq_kl || eq_hl)
                    mult = MULT_6;
                else if ((sum_hkl == '0) && (zeros != 2'd0))
                    mult = MULT_6;
                else
                    mult = MULT_12;
            end
            LC_TRIG_M1_H:
            begin
                priority if (eq_hk)
                    mult = eq_ki ? MULT_2 : MULT_6;
                else if (eq_ki || eq_hi)
                    mult = MULT_6;
                else if (zl && (zh || zk || zi))
                    mult = MULT_6;
                else
                    mult = MULT_12;
            end
            LC_TRIG_M2_H:
            begin
                priority if (zh)
                    mult = zk ? MULT_2 : MULT_6;
                else if (zk || zi)
                    mult = MULT_6;
                else if (zl && (eq_hk || eq_hi || eq_ki))
                    mult = MULT_6;
                else
                    mult = MULT_12;
            end
            default:
                mult = MULT_2;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/laue_reflection_multiplicity_top.sv
// Top level of the Laue reflection multiplicity block: register port and two-stage pipeline.
// Instantiates lrm_calc; depends on lrm_pkg.
`default_nettype none

// Returns, for each signed Miller index triple, the number of symmetry-equivalent
// reflections under the Laue class held in the laue_class register (byte address 0),
// with the unique axis for the monoclinic and tetragonal classes in unique_axis
// (byte address 4). One triple is accepted every clock cycle while in_stall is low. Each
// beat is held first in the input register and then in the result register, with the
// whole comparison tree between them; it stays in the result register until it is taken.
// in_stall rises only when both registers are full and the result side is stalling.
// Write the registers only while no beat is in flight.
module laue_reflection_multiplicity_top #(
    parameter int INDEX_WIDTH = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [INDEX_WIDTH-1:0] index_h,
    input  wire logic [INDEX_WIDTH-1:0] index_k,
    input  wire logic [INDEX_WIDTH-1:0] index_l,
    // Result channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [5:0]                  multiplicity
);
    import lrm_pkg::*;

    // Configuration registers.
    cfg_t cfg_reg, cfg_next;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_LAUE_CLASS:  cfg_next.laue_class  = pwdata[3:0];
                REG_UNIQUE_AXIS: cfg_next.unique_axis = pwdata[1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.laue_class  <= LAUE_CLASS_RESET;
            cfg_reg.unique_axis <= UNIQUE_AXIS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data.
    always_comb
    begin
        unique case (paddr[2])
            REG_LAUE_CLASS:  prdata = {28'd0, cfg_reg.laue_class};
            REG_UNIQUE_AXIS: prdata = {30'd0, cfg_reg.unique_axis};
            default:         prdata = 32'd0;
        endcase
    end

    // Pipeline flow control: each stage moves on when the stage after it is free.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s1_free, s2_free, in_accept;

    assign s2_free   = !s2_valid_reg || !out_stall;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign in_stall  = !s1_free;
    assign in_accept = in_valid && s1_free;

    always_comb
    begin
        s1_valid_next = s1_free ? in_valid : s1_valid_reg;
        s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Input register.
    logic [INDEX_WIDTH-1:0] h_reg, k_reg, l_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            h_reg <= index_h;
            k_reg <= index_k;
            l_reg <= index_l;
        end
    end

    // Multiplicity logic between the two registers.
    logic [5:0] mult_next;

    lrm_calc #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_calc (
        .h    (h_reg),
        .k    (k_reg),
        .l    (l_reg),
        .cfg  (cfg_reg),
        .mult (mult_next)
    );

    // Result register.
    logic [5:0] mult_reg;

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            mult_reg <= mult_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign multiplicity = mult_reg;

`ifndef SYNTHESIS
    // A stall on the input side only arises from a full, stalled result stage.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid && out_stall))
        else $error("input stalled without a stalled result beat");

    // An accepted beat lands in the input register.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat lost at the input register");

    // A beat leaving the input register reaches the result register.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_free) |=> out_valid)
        else $error("beat lost between input and result registers");

    // Every delivered result is an even value from 2 to 48.
    a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (multiplicity >= MULT_2 && multiplicity <= MULT_48
                       && !multiplicity[0]))
        else $error("multiplicity out of range");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the Laue reflection multiplicity block.
// Drives index triples and APB register writes, predicts each multiplicity and checks every
// result beat; depends on lrm_pkg and laue_reflection_multiplicity_top.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lrm_pkg::*;

    localparam int INDEX_WIDTH    = 8;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_ITEMS    = 38;
    localparam int CALM_ITEMS     = 120;
    localparam int CALM_PHASE     = 8;
    localparam int IDLE_PCT       = 28;
    localparam int CLASS_CODES    = 16;
    localparam int AXIS_CODES     = 4;

    localparam logic [2:0] ADDR_LAUE_CLASS  = {REG_LAUE_CLASS, 2'b00};
    localparam logic [2:0] ADDR_UNIQUE_AXIS = {REG_UNIQUE_AXIS, 2'b00};

    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {1'b0, {(INDEX_WIDTH-1){1'b1}}};
    localparam logic [INDEX_WIDTH-1:0] IDX_MIN = {1'b1, {(INDEX_WIDTH-1){1'b0}}};
    localparam logic [INDEX_WIDTH-1:0] IDX_MIN_PLUS_ONE = IDX_MIN + 1'b1;
    localparam logic [INDEX_WIDTH-1:0] IDX_MINUS_ONE = {INDEX_WIDTH{1'b1}};

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] h;
        logic [INDEX_WIDTH-1:0] k;
        logic [INDEX_WIDTH-1:0] l;
    } triple_t;

    typedef struct packed {
        triple_t    idx;
        logic [3:0] cls;
        logic [1:0] axis;
        logic [5:0] mult;
    } mult_due_t;

    // Clock, reset and block ports; every input starts at a known value.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [INDEX_WIDTH-1:0] index_h = '0;
    logic [INDEX_WIDTH-1:0] index_k = '0;
    logic [INDEX_WIDTH-1:0] index_l = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [5:0]             multiplicity;

    // Testbench copy of the configuration registers.
    logic [3:0] cfg_laue_class  = LAUE_CLASS_RESET;
    logic [1:0] cfg_unique_axis = UNIQUE_AXIS_RESET;

    triple_t   pending_triples[$];
    mult_due_t due_multiplicities[$];
    triple_t   launch_triple;
    mult_due_t arrived_due;

    int gap_pct = IDLE_PCT;
    int stall_pct = IDLE_PCT;
    int cycle_count = 0;
    int mismatch_count = 0;
    int beats_accepted = 0;
    int results_checked = 0;
    int settings_run = 0;

    laue_reflection_multiplicity_top #(.INDEX_WIDTH(INDEX_WIDTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .index_h      (index_h),
        .index_k      (index_k),
        .index_l      (index_l),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .multiplicity (multiplicity)
    );

    always #5 clk = ~clk;

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, due_multiplicities.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("Mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Appends a triple to the tail of the stimulus queue.
    function automatic void queue_triple(input triple_t t);
        pending_triples = {pending_triples, t};
    endfunction

    // Appends a prediction to the tail of the expected results.
    function automatic void queue_due(input mult_due_t d);
        due_multiplicities = {due_multiplicities, d};
    endfunction

    // Multiplicity of a triple under the class and axis currently programmed.
    function automatic logic [5:0] predict_multiplicity(input triple_t t);
        int h, k, l, i, u, p, q;
        int ah, ak, al, ap, aq;
        int zeros;
        int v[3];
        int ax;
        h = $signed(t.h);
        k = $signed(t.k);
        l = $signed(t.l);
        i = -h - k;
        ah = (h < 0) ? -h : h;
        ak = (k < 0) ? -k : k;
        al = (l < 0) ? -l : l;
        zeros = int'(h == 0) + int'(k == 0) + int'(l == 0);
        // The spare axis code behaves as c; the other two axes follow cyclically.
        ax = (cfg_unique_axis == AXIS_A) ? 0 : (cfg_unique_axis == AXIS_B) ? 1 : 2;
        v[0] = h;
        v[1] = k;
        v[2] = l;
        u = v[ax];
        p = v[(ax + 1) % 3];
        q = v[(ax + 2) % 3];
        ap = (p < 0) ? -p : p;
        aq = (q < 0) ? -q : q;

        case (cfg_laue_class)
            LC_MONOCLINIC:
            begin
                if (u == 0 || (p == 0 && q == 0)) return MULT_2;
                return MULT_4;
            end
            LC_ORTHO:
            begin
                if (zeros == 0) return MULT_8;
                if (zeros == 1) return MULT_4;
                return MULT_2;
            end
            LC_TETRA_LOW:
            begin
                if (u == 0) return MULT_4;
                if (p == 0 && q == 0) return MULT_2;
                return MULT_8;
            end
            LC_TETRA_HIGH:
            begin
                if (u == 0)
                begin
                    if (p == 0 || ap == aq || q == 0) return MULT_4;
                    return MULT_8;
                end
                if (p == 0) return (q == 0) ? MULT_2 : MULT_8;
                if (q == 0 || ap == aq) return MULT_8;
                return MULT_16;
            end
            LC_CUBIC_LOW:
            begin
                if (ah == ak && ak == al) return MULT_8;
                if (zeros == 0) return MULT_24;
                if (zeros == 1) return MULT_12;
                return MULT_6;
            end
            LC_CUBIC_HIGH:
            begin
                if (zeros == 2) return MULT_6;
                if (zeros == 1)
                begin
                    if (ah == ak || ak == al || ah == al) return MULT_12;
                    return MULT_24;
                end
                if (ah == ak) return (ak == al) ? MULT_8 : MULT_24;
                if (ah == al || ak == al) return MULT_24;
                return MULT_48;
            end
            LC_HEX_LOW:
            begin
                if (l == 0) return MULT_6;
                if (h == 0 && k == 0) return MULT_2;
                return MULT_12;
            end
            LC_HEX_HIGH:
            begin
                if (l == 0)
                begin
                    if (h == 0 || k == 0 || i == 0) return MULT_6;
                    if (h == k || k == i || h == i) return MULT_6;
                    return MULT_12;
                end
                if (h == 0) return (k == 0) ? MULT_2 : MULT_12;
                if (k == 0 || i == 0 || h == k || k == i || h == i) return MULT_12;
                return MULT_24;
            end
            LC_TRIG_R:
            begin
                if (h == k && k == l) return MULT_2;
                return MULT_6;
            end
            LC_TRIG_H:
            begin
                if (h == 0 && k == 0) return MULT_2;
                return MULT_6;
            end
            LC_TRIG_M_R:
            begin
                if (h == k) return (k == l) ? MULT_2 : MULT_6;
                if (k == l || h == l) return MULT_6;
                if (h + k + l == 0 && zeros != 0) return MULT_6;
                return MULT_12;
            end
            LC_TRIG_M1_H:
            begin
                if (h == k) return (k == i) ? MULT_2 : MULT_6;
                if (k == i || h == i) return MULT_6;
                if (l == 0 && (h == 0 || k == 0 || i == 0)) return MULT_6;
                return MULT_12;
            end
            LC_TRIG_M2_H:
            begin
                if (h == 0) return (k == 0) ? MULT_2 : MULT_6;
                if (k == 0 || i == 0) return MULT_6;
                if (l == 0 && (h == k || h == i || k == i)) return MULT_6;
                return MULT_12;
            end
            // Triclinic and the two unused class codes.
            default: return MULT_2;
        endcase
    endfunction

    // One index, biased towards zero, small values and the extremes of the range.
    function automatic logic [INDEX_WIDTH-1:0] random_index();
        logic [INDEX_WIDTH-1:0] r;
        r = INDEX_WIDTH'($urandom);
        case ($urandom_range(0, 5))
            0: r = '0;
            1: r = INDEX_WIDTH'($urandom_range(1, 3));
            2: r = -(INDEX_WIDTH'($urandom_range(1, 3)));
            3:
            begin
                case ($urandom_range(0, 3))
                    0: r = IDX_MAX;
                    1: r = IDX_MIN;
                    2: r = IDX_MIN_PLUS_ONE;
                    default: r = IDX_MINUS_ONE;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    // Triples that mostly satisfy one of the equalities the classes test for.
    function automatic triple_t random_triple();
        triple_t t;
        logic [INDEX_WIDTH-1:0] m;
        t.h = random_index();
        t.k = random_index();
        t.l = random_index();
        m = random_index();
        case ($urandom_range(0, 9))
            0: t.k = t.h;
            1: t.k = -t.h;
            2: t.l = $urandom_range(0, 1) ? t.h : -t.h;
            3: t.l = $urandom_range(0, 1) ? t.k : -t.k;
            4:
            begin
                // Equal magnitudes with random signs.
                t.h = $urandom_range(0, 1) ? m : -m;
                t.k = $urandom_range(0, 1) ? m : -m;
                t.l = $urandom_range(0, 1) ? m : -m;
            end
            5: t.h = -(t.k << 1);           // k equals the fourth index
            6: t.k = -(t.h << 1);           // h equals the fourth index
            7: t.l = -(t.h + t.k);          // indices sum to zero
            default: ;
        endcase
        return t;
    endfunction

    // Input driver: records each accepted beat, then loads the next triple when free.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                launch_triple = '{h: index_h, k: index_k, l: index_l};
                queue_due('{idx: launch_triple, cls: cfg_laue_class,
                            axis: cfg_unique_axis,
                            mult: predict_multiplicity(launch_triple)});
                beats_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_triples.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    launch_triple = pending_triples.pop_front();
                    in_valid <= 1'b1;
                    index_h  <= launch_triple.h;
                    index_k  <= launch_triple.k;
                    index_l  <= launch_triple.l;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result monitor: compares each accepted beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_multiplicities.size() == 0)
            begin
                report_mismatch($sformatf("result beat %0d with no triple outstanding",
                                          multiplicity));
            end
            else
            begin
                arrived_due = due_multiplicities.pop_front();
                results_checked++;
                if (multiplicity !== arrived_due.mult)
                    report_mismatch($sformatf(
                        "class %0d axis %0d hkl (%0d,%0d,%0d): got %0d, want %0d",
                        arrived_due.cls, arrived_due.axis, $signed(arrived_due.idx.h),
                        $signed(arrived_due.idx.k), $signed(arrived_due.idx.l),
                        multiplicity, arrived_due.mult));
            end
        end
    end

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes a register and reads it back.
    task automatic program_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] rdata;
        apb_transfer(1'b1, addr, value, rdata);
        apb_transfer(1'b0, addr, '0, rdata);
        if (rdata !== value)
            report_mismatch($sformatf("register at %0d reads %0h, written %0h",
                                      addr, rdata, value));
    endtask

    // One setting: program it if asked, queue the triples, then wait for every result to drain.
    task automatic run_setting(input logic [3:0] cls, input logic [1:0] axis,
                               input bit do_program, input bit with_zero, input int count);
        if (do_program)
        begin
            program_register(ADDR_LAUE_CLASS, {28'd0, cls});
            cfg_laue_class = cls;
            program_register(ADDR_UNIQUE_AXIS, {30'd0, axis});
            cfg_unique_axis = axis;
        end
        if (settings_run == CALM_PHASE)
        begin
            gap_pct = 0;
            stall_pct = 0;
            count = CALM_ITEMS;
        end
        else
        begin
            gap_pct = IDLE_PCT;
            stall_pct = IDLE_PCT;
        end
        if (with_zero)
            queue_triple('0);
        repeat (count) queue_triple(random_triple());
        while (pending_triples.size() != 0 || in_valid || due_multiplicities.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        settings_run++;
    endtask

    // Stimulus: reset, extremes under the reset setting, then every class and axis code.
    initial
    begin
        int axis_passes;
        logic [3:0] cls;
        logic [1:0] axis;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_triple('{h: IDX_MAX, k: IDX_MAX, l: IDX_MAX});
        queue_triple('{h: IDX_MIN, k: IDX_MIN, l: IDX_MIN});
        queue_triple('{h: IDX_MIN, k: IDX_MAX, l: '0});
        queue_triple('{h: IDX_MAX, k: IDX_MIN, l: IDX_MINUS_ONE});
        run_setting(LAUE_CLASS_RESET, UNIQUE_AXIS_RESET, 1'b0, 1'b1, PHASE_ITEMS);

        for (int c = CLASS_CODES - 1; c >= 0; c--)
        begin
            cls = 4'(c);
            axis_passes = (cls == LC_MONOCLINIC || cls == LC_TETRA_LOW ||
                           cls == LC_TETRA_HIGH) ? AXIS_CODES : 1;
            for (int a = 0; a < axis_passes; a++)
            begin
                axis = (axis_passes == AXIS_CODES) ? 2'(a)
                                                   : 2'($urandom_range(0, AXIS_CODES - 1));
                run_setting(cls, axis, 1'b1, a == 0, PHASE_ITEMS);
            end
        end

        if (due_multiplicities.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_multiplicities.size()));

        $display("Covered %0d register settings over all class and axis codes.", settings_run);
        $display("Index triples accepted: %0d, results checked: %0d, mismatches: %0d.",
                 beats_accepted, results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: laue_reflection_multiplicity_top.f
design/lrm_pkg.sv
design/lrm_calc.sv
design/laue_reflection_multiplicity_top.sv
test/tb_top.sv
